### design/hsv_pkg.sv
// Shared types and constants for the HSV to RGB converter.
`default_nettype none

package hsv_pkg;

	// Hue and scale constants
	localparam logic [15:0] HUE_RECIP   = 16'd27962;  // floor(2^24 / 600)
	localparam logic [9:0]  SECTOR_SPAN = 10'd600;
	localparam logic [9:0]  FULL_SCALE  = 10'd1000;
	localparam logic [19:0] FRAC_SCALE  = 20'd600000;
	localparam logic [5:0]  MOD6_RECIP  = 6'd43;      // floor(2^8 / 6) + 1
	localparam logic [2:0]  SECTOR_CNT  = 3'd6;

	// Byte rounding: floor((17*N + 2e7) / 4e7) = floor(((17*N + 2e7) >> 9) / 78125)
	localparam logic [4:0]  LEVEL_MUL   = 5'd17;
	localparam logic [24:0] ROUND_BIAS  = 25'd20000000;
	localparam logic [16:0] BYTE_DIV    = 17'd78125;
	localparam logic [16:0] BYTE_RECIP  = 17'd109951; // floor(2^33 / 78125)

	// Sector codes
	localparam logic [2:0] SEC_RED_GREEN  = 3'd0;
	localparam logic [2:0] SEC_GREEN_RED  = 3'd1;
	localparam logic [2:0] SEC_GREEN_BLUE = 3'd2;
	localparam logic [2:0] SEC_BLUE_GREEN = 3'd3;
	localparam logic [2:0] SEC_BLUE_RED   = 3'd4;
	localparam logic [2:0] SEC_RED_BLUE   = 3'd5;

	// Queue and pipeline sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int BACK_STAGES = 5;
	localparam int CAPACITY    = 1 + QUEUE_DEPTH + BACK_STAGES;
	localparam int CAP_W       = $clog2(CAPACITY + 1) + 1;

	typedef struct packed {
		logic [2:0] sector;
		logic [9:0] rem;
		logic [9:0] sat;
		logic [9:0] val;
	} hsv_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hsv_qstat_t;

endpackage

`default_nettype wire

### design/hsv_front.sv
// Front end: capture, saturate, and split hue into sector and remainder.
`default_nettype none

module hsv_front import hsv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] hue_tenths,
	input  wire logic [15:0] sat_tenths,
	input  wire logic [15:0] val_tenths,
	input  wire hsv_qstat_t  qstat,
	output logic             push,
	output hsv_item_t        push_item
);

	logic        valid_s1;
	logic [15:0] hue_s1;
	logic [6:0]  quot_s1;
	logic [9:0]  sat_s1;
	logic [9:0]  val_s1;

	logic [30:0] hue_prod;
	logic [15:0] base;
	logic [15:0] rem_full;
	logic [10:0] rem_raw;
	logic        wrap;
	logic [6:0]  quot;
	logic [12:0] mod_prod;
	logic [4:0]  six_cnt;
	logic [6:0]  six_mul;

	assign in_stall = valid_s1 && qstat.full;
	assign hue_prod = 31'(hue_tenths) * 31'(HUE_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			hue_s1  <= hue_tenths;
			quot_s1 <= hue_prod[30:24];
			sat_s1  <= (sat_tenths > 16'(FULL_SCALE)) ? FULL_SCALE : sat_tenths[9:0];
			val_s1  <= (val_tenths > 16'(FULL_SCALE)) ? FULL_SCALE : val_tenths[9:0];
		end
	end

	// Quotient estimate may be one short: fix it up on the remainder
	always_comb begin
		base     = 16'(quot_s1) * 16'(SECTOR_SPAN);
		rem_full = hue_s1 - base;
		rem_raw  = rem_full[10:0];
		wrap     = rem_raw >= 11'(SECTOR_SPAN);
		quot     = quot_s1 + 7'(wrap);
		mod_prod = 13'(quot) * 13'(MOD6_RECIP);
		six_cnt  = mod_prod[12:8];
		six_mul  = 7'(six_cnt) * 7'(SECTOR_CNT);
		push_item.sector = 3'(quot - six_mul);
		push_item.rem    = wrap ? 10'(rem_raw - 11'(SECTOR_SPAN)) : rem_raw[9:0];
		push_item.sat    = sat_s1;
		push_item.val    = val_s1;
	end

	assign push = valid_s1 && !qstat.full;

endmodule

`default_nettype wire

### design/hsv_queue.sv
// Short queue between the front end and the arithmetic back end.
`default_nettype none

module hsv_queue import hsv_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire hsv_item_t push_item,
	input  wire logic      pop,
	output hsv_item_t      head,
	output hsv_qstat_t     qstat
);

	hsv_item_t           entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign qstat.full  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

### design/hsv_back.sv
// Back end: form p, q, t per sector, scale by value and round to bytes.
`default_nettype none

module hsv_back import hsv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire hsv_item_t  head,
	input  wire hsv_qstat_t qstat,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);

	logic advance;

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [2:0][19:0]  lvl_s1;
	logic [9:0]        val_s1;
	logic [2:0][29:0]  num_s2;
	logic [2:0][24:0]  scaled_s3;
	logic [2:0][24:0]  scaled_s4;
	logic [2:0][8:0]   est_s4;
	logic [2:0][7:0]   byte_s5;

	logic [19:0]       s_rem, s_comp, a_v, a_p, a_q, a_t;
	logic [9:0]        comp_rem;
	logic [2:0][19:0]  lvl;
	logic [2:0][33:0]  biased;
	logic [2:0][41:0]  recip_prod;
	logic [2:0][24:0]  back_mul;
	logic [2:0][24:0]  resid;

	// Whole back end moves together; hold only while a finished result waits
	assign advance = !(valid_s5 && out_stall);
	assign pop     = advance && !qstat.empty;

	always_comb begin
		comp_rem = SECTOR_SPAN - head.rem;
		s_rem    = 20'(head.sat) * 20'(head.rem);
		s_comp   = 20'(head.sat) * 20'(comp_rem);
		a_v      = FRAC_SCALE;
		a_p      = 20'(FULL_SCALE - head.sat) * 20'(SECTOR_SPAN);
		a_q      = FRAC_SCALE - s_rem;
		a_t      = FRAC_SCALE - s_comp;
		unique case (head.sector)
			SEC_RED_GREEN: begin
				lvl = {a_p, a_t, a_v};
			end
			SEC_GREEN_RED: begin
				lvl = {a_p, a_v, a_q};
			end
			SEC_GREEN_BLUE: begin
				lvl = {a_t, a_v, a_p};
			end
			SEC_BLUE_GREEN: begin
				lvl = {a_v, a_q, a_p};
			end
			SEC_BLUE_RED: begin
				lvl = {a_v, a_p, a_t};
			end
			default: begin
				lvl = {a_q, a_p, a_v};
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			biased[i]     = 34'(num_s2[i]) * 34'(LEVEL_MUL) + 34'(ROUND_BIAS);
			recip_prod[i] = 42'(scaled_s3[i]) * 42'(BYTE_RECIP);
			back_mul[i]   = 25'(est_s4[i]) * 25'(BYTE_DIV);
			resid[i]      = scaled_s4[i] - back_mul[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= !qstat.empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lvl_s1 <= lvl;
			val_s1 <= head.val;
			for (int i = 0; i < 3; i++) begin
				num_s2[i]    <= 30'(val_s1) * 30'(lvl_s1[i]);
				scaled_s3[i] <= biased[i][33:9];
				scaled_s4[i] <= scaled_s3[i];
				est_s4[i]    <= recip_prod[i][41:33];
				// estimate is at most one short
				byte_s5[i]   <= (resid[i] >= 25'(BYTE_DIV)) ? est_s4[i][7:0] + 8'd1
				                                             : est_s4[i][7:0];
			end
		end
	end

	assign out_valid = valid_s5;
	assign red       = byte_s5[0];
	assign green     = byte_s5[1];
	assign blue      = byte_s5[2];

endmodule

`default_nettype wire

### design/hsv_to_rgb_converter_core.sv
// HSV to RGB converter top level: front end, queue and arithmetic back end.
// A result goes from the front register through the queue and back stages s1-s5.
// Throughput: one request per cycle while out_stall is low (single-issue back end).
// Up to 10 requests in flight; in_stall needs a full 4-entry queue and a busy front stage.
// Reset (arst_n low) clears the valid flags and queue pointers at once; no clearing pass.
`default_nettype none

module hsv_to_rgb_converter_core import hsv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] hue_tenths,
	input  wire logic [15:0] sat_tenths,
	input  wire logic [15:0] val_tenths,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue
);

	hsv_qstat_t qstat;
	hsv_item_t  push_item;
	hsv_item_t  head;
	logic       push;
	logic       pop;

	hsv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue_tenths (hue_tenths),
		.sat_tenths (sat_tenths),
		.val_tenths (val_tenths),
		.qstat      (qstat),
		.push       (push),
		.push_item  (push_item)
	);

	hsv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	hsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

`default_nettype wire

### design/hsv_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
`default_nettype none

module hsv_checker import hsv_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  red,
	input wire logic [7:0]  green,
	input wire logic [7:0]  blue
);

	logic             in_take;
	logic             out_take;
	logic [CAP_W-1:0] pending_q;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	// Track requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_take && !out_take) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_take && !in_take) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(red) && $stable(green) && $stable(blue))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result shown with no request outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CAP_W'(CAPACITY))
		else $error("more requests in flight than the design can hold");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == CAP_W'(CAPACITY) && !out_take |-> in_stall)
		else $error("request accepted while every slot is taken");

endmodule

bind hsv_to_rgb_converter_core hsv_checker u_hsv_checker (.*);

`default_nettype wire
